[design/dwdiv_pkg.sv]
// ----------------------------------------------------------------------------
// dwdiv_pkg
// Shared widths, status codes and controller command types for the
// double-word divider.
// ----------------------------------------------------------------------------
package dwdiv_pkg;

    localparam int WORD_BITS  = 32;
    localparam int DWORD_BITS = 2 * WORD_BITS;

    // Stream payload widths, rounded up to whole bytes
    localparam int S_TDATA_BITS = ((3 * WORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((3 * WORD_BITS + 7) / 8) * 8;
    localparam int S_TUSER_BITS = 3;
    localparam int M_TUSER_BITS = 2;

    // One quotient bit per step over the whole dividend
    localparam int STEP_CNT_BITS = $clog2(DWORD_BITS);

    typedef enum logic [M_TUSER_BITS-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_RANGE    = 2'd2
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture a new request
        logic prep;       // take magnitudes of the operands
        logic step;       // one restoring-division step
        logic fix_sign;   // apply signs to quotient and remainder
        logic fix_floor;  // floored-division correction
        logic finish;     // range check and load the output register
    } cmd_t;

endpackage

[design/double_word_divider_unit.sv]
// ----------------------------------------------------------------------------
// double_word_divider_unit
// Divides a two-word dividend by a one-word divisor, unsigned or signed,
// truncating or floored, with a narrow or wide quotient.
// ----------------------------------------------------------------------------
// Sequence: accept, operand prep, 64 shift/subtract steps, sign fix, floor fix,
//   output load; a zero divisor goes from operand prep straight to output load.
// Requests are taken one at a time, set by the single radix-2 subtract
//   unit that produces one quotient bit per cycle.
// The output register lets the next request in while a result waits.
// Reset: rst_n asynchronous, active low; clears the sequencer and output
//   valid, payload registers are not reset.
module double_word_divider_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // dividend_high, dividend_low, divisor (from bit 0 up)
    input  logic [dwdiv_pkg::S_TDATA_BITS-1:0] s_axis_tdata,
    // signed_mode, floor_mode, wide_quotient (from bit 0 up)
    input  logic [dwdiv_pkg::S_TUSER_BITS-1:0] s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // quotient_low, quotient_high, remainder (from bit 0 up)
    output logic [dwdiv_pkg::M_TDATA_BITS-1:0] m_axis_tdata,
    // status
    output logic [dwdiv_pkg::M_TUSER_BITS-1:0] m_axis_tuser
);
    import dwdiv_pkg::*;

    cmd_t                 cmd;
    logic                 divisor_zero;
    logic [WORD_BITS-1:0] quotient_low;
    logic [WORD_BITS-1:0] quotient_high;
    logic [WORD_BITS-1:0] remainder;
    status_t              status;

    dwdiv_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (s_axis_tvalid),
        .req_ready    (s_axis_tready),
        .rsp_valid    (m_axis_tvalid),
        .rsp_ready    (m_axis_tready),
        .divisor_zero (divisor_zero),
        .cmd          (cmd)
    );

    dwdiv_datapath u_datapath
    (
        .clk              (clk),
        .cmd              (cmd),
        .in_dividend_high (s_axis_tdata[WORD_BITS-1:0]),
        .in_dividend_low  (s_axis_tdata[2*WORD_BITS-1:WORD_BITS]),
        .in_divisor       (s_axis_tdata[3*WORD_BITS-1:2*WORD_BITS]),
        .in_signed_mode   (s_axis_tuser[0]),
        .in_floor_mode    (s_axis_tuser[1]),
        .in_wide_quotient (s_axis_tuser[2]),
        .divisor_zero     (divisor_zero),
        .quotient_low     (quotient_low),
        .quotient_high    (quotient_high),
        .remainder        (remainder),
        .status           (status)
    );

    assign m_axis_tdata = M_TDATA_BITS'({remainder, quotient_high, quotient_low});
    assign m_axis_tuser = status;

    // One request at a time: no second accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while previous one in flight");

    // Loading a result always presents it on the next cycle
    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("result loaded but not presented");

    // Error results carry an all-zero payload
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_DIV_ZERO ||
                           m_axis_tuser == STATUS_RANGE)) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero payload");

endmodule

[design/dwdiv_datapath.sv]
// ----------------------------------------------------------------------------
// dwdiv_datapath
// Operand registers, radix-2 shift/subtract unit, sign and floor fix-up, and
// the output payload register of the double-word divider.
// ----------------------------------------------------------------------------
module dwdiv_datapath
(
    input  logic                            clk,
    input  dwdiv_pkg::cmd_t                 cmd,
    input  logic [dwdiv_pkg::WORD_BITS-1:0] in_dividend_high,
    input  logic [dwdiv_pkg::WORD_BITS-1:0] in_dividend_low,
    input  logic [dwdiv_pkg::WORD_BITS-1:0] in_divisor,
    input  logic                            in_signed_mode,
    input  logic                            in_floor_mode,
    input  logic                            in_wide_quotient,
    output logic                            divisor_zero,
    output logic [dwdiv_pkg::WORD_BITS-1:0] quotient_low,
    output logic [dwdiv_pkg::WORD_BITS-1:0] quotient_high,
    output logic [dwdiv_pkg::WORD_BITS-1:0] remainder,
    output dwdiv_pkg::status_t              status
);
    import dwdiv_pkg::*;

    // num_reg holds the dividend and collects quotient bits as it shifts out
    logic [DWORD_BITS-1:0] num_reg, num_next;
    logic [WORD_BITS-1:0]  rem_reg, rem_next;
    logic [WORD_BITS-1:0]  ad_reg, ad_next;
    logic [WORD_BITS-1:0]  d_reg;
    logic                  sgn_reg, flr_reg, wide_reg;
    logic                  nneg_reg, nneg_next;
    logic                  dneg_reg, dneg_next;

    logic [WORD_BITS-1:0]  ql_reg, ql_next;
    logic [WORD_BITS-1:0]  qh_reg, qh_next;
    logic [WORD_BITS-1:0]  r_reg, r_next;
    status_t               st_reg, st_next;

    logic [WORD_BITS-1:0]  shifted;
    logic [WORD_BITS:0]    diff;
    logic                  take;
    logic                  opp_sign;
    logic                  fits;
    logic [WORD_BITS-1:0]  q_hi;
    logic [WORD_BITS-1:0]  q_lo;

    assign divisor_zero = (d_reg == '0);
    assign opp_sign     = nneg_reg ^ dneg_reg;
    assign q_hi         = num_reg[DWORD_BITS-1:WORD_BITS];
    assign q_lo         = num_reg[WORD_BITS-1:0];

    // Shift/subtract: the bit shifted out of rem acts as a 33rd bit
    assign shifted = {rem_reg[WORD_BITS-2:0], num_reg[DWORD_BITS-1]};
    assign diff    = {1'b0, shifted} - {1'b0, ad_reg};
    assign take    = rem_reg[WORD_BITS-1] | ~diff[WORD_BITS];

    always_comb
    begin
        if (sgn_reg)
        begin
            fits = ((q_hi == '0) && !q_lo[WORD_BITS-1]) ||
                   ((q_hi == '1) && q_lo[WORD_BITS-1]);
        end
        else
        begin
            fits = (q_hi == '0);
        end
    end

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        ad_next   = ad_reg;
        nneg_next = nneg_reg;
        dneg_next = dneg_reg;
        ql_next   = ql_reg;
        qh_next   = qh_reg;
        r_next    = r_reg;
        st_next   = st_reg;

        if (cmd.load)
        begin
            num_next = {in_dividend_high, in_dividend_low};
            rem_next = '0;
        end

        if (cmd.prep)
        begin
            nneg_next = sgn_reg & num_reg[DWORD_BITS-1];
            dneg_next = sgn_reg & d_reg[WORD_BITS-1];
            if (sgn_reg && num_reg[DWORD_BITS-1])
            begin
                num_next = -num_reg;
            end
            ad_next = (sgn_reg && d_reg[WORD_BITS-1]) ? -d_reg : d_reg;
        end

        if (cmd.step)
        begin
            rem_next = take ? diff[WORD_BITS-1:0] : shifted;
            num_next = {num_reg[DWORD_BITS-2:0], take};
        end

        if (cmd.fix_sign)
        begin
            if (opp_sign)
            begin
                num_next = -num_reg;
            end
            if (nneg_reg)
            begin
                rem_next = -rem_reg;
            end
        end

        // Floored result: step the quotient down and move the remainder
        // over to the divisor's sign
        if (cmd.fix_floor)
        begin
            if (sgn_reg && flr_reg && (rem_reg != '0) && opp_sign)
            begin
                num_next = num_reg - DWORD_BITS'(1);
                rem_next = rem_reg + d_reg;
            end
        end

        if (cmd.finish)
        begin
            if (divisor_zero)
            begin
                ql_next = '0;
                qh_next = '0;
                r_next  = '0;
                st_next = STATUS_DIV_ZERO;
            end
            else if (!wide_reg && !fits)
            begin
                ql_next = '0;
                qh_next = '0;
                r_next  = '0;
                st_next = STATUS_RANGE;
            end
            else
            begin
                ql_next = q_lo;
                qh_next = wide_reg ? q_hi : '0;
                r_next  = rem_reg;
                st_next = STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            d_reg    <= in_divisor;
            sgn_reg  <= in_signed_mode;
            flr_reg  <= in_floor_mode;
            wide_reg <= in_wide_quotient;
        end
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        ad_reg   <= ad_next;
        nneg_reg <= nneg_next;
        dneg_reg <= dneg_next;
        ql_reg   <= ql_next;
        qh_reg   <= qh_next;
        r_reg    <= r_next;
        st_reg   <= st_next;
    end

    assign quotient_low  = ql_reg;
    assign quotient_high = qh_reg;
    assign remainder     = r_reg;
    assign status        = st_reg;

endmodule

[design/dwdiv_ctrl.sv]
// ----------------------------------------------------------------------------
// dwdiv_ctrl
// Sequencer for the double-word divider: request handshake, step counter,
// fix-up sequencing and output valid.
// ----------------------------------------------------------------------------
module dwdiv_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  logic            divisor_zero,
    output dwdiv_pkg::cmd_t cmd
);
    import dwdiv_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_DIV   = 6'b000100,
        S_SIGN  = 6'b001000,
        S_FLOOR = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    localparam logic [STEP_CNT_BITS-1:0] LAST_STEP = STEP_CNT_BITS'(DWORD_BITS - 1);

    state_t                   state_reg, state_next;
    logic [STEP_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                // zero divisor skips straight to the result
                if (divisor_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.prep   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + STEP_CNT_BITS'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                cmd.fix_sign = 1'b1;
                state_next   = S_FLOOR;
            end
            S_FLOOR:
            begin
                cmd.fix_floor = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

[dv/double_word_divider_unit_test.sv]
// ----------------------------------------------------------------------------
// double_word_divider_unit_test
// Self-checking bench for the double-word divider. A directed table covers
// zero divisors, narrowing overflow, sign and floor corrections and the
// most negative dividend. A random part follows under several sender and
// receiver idling patterns. Every result is compared in request order against
// the typed result of its table row, or else an internal division model.
// ----------------------------------------------------------------------------
module double_word_divider_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import dwdiv_pkg::*;

    localparam int HALF_PERIOD      = 2;
    localparam int RESET_CYCLES     = 6;
    localparam int LATENCY_CYCLES   = 69;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int DIRECTED_ROWS    = 23;

    typedef logic [WORD_BITS-1:0]  word_t;
    typedef logic [DWORD_BITS-1:0] dword_t;

    typedef struct packed {
        word_t dividend_high;
        word_t dividend_low;
        word_t divisor;
        logic  signed_mode;
        logic  floor_mode;
        logic  wide_quotient;
    } div_request_t;

    typedef struct packed {
        word_t   quotient_low;
        word_t   quotient_high;
        word_t   remainder;
        status_t status;
    } div_result_t;

    typedef struct packed {
        div_request_t req;
        logic         has_result;
        div_result_t  res;
    } directed_row_t;

    localparam div_result_t NO_RESULT = '0;

    // sender idle / receiver stall percentages per phase
    localparam int PHASE_SEND_IDLE [4] = '{0, 84, 0, 30};
    localparam int PHASE_STALL     [4] = '{0, 0, 84, 30};

    // hi, lo, divisor, signed, floor, wide; typed result where obvious
    directed_row_t directed_table [DIRECTED_ROWS] = '{
        '{'{32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{32'h0, 32'h0, 32'h0, STATUS_DIV_ZERO}},
        '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, 1'b1, 1'b1, 1'b1}, 1'b1,
          '{32'h0, 32'h0, 32'h0, STATUS_DIV_ZERO}},
        '{'{32'h0, 32'd100, 32'd7, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{32'd14, 32'h0, 32'd2, STATUS_OK}},
        '{'{32'h1, 32'h0, 32'h1, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{32'h0, 32'h0, 32'h0, STATUS_RANGE}},
        '{'{32'h1, 32'h0, 32'h1, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{32'h0, 32'h1, 32'h0, STATUS_OK}},
        '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0, STATUS_OK}},
        '{'{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b1}, 1'b1,
          '{32'h1, 32'h1, 32'h0, STATUS_OK}},
        '{'{32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b0}, 1'b0,
          NO_RESULT},
        '{'{32'hFFFFFFFF, 32'hFFFFFFF9, 32'd2, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{32'hFFFFFFFD, 32'h0, 32'hFFFFFFFF, STATUS_OK}},
        '{'{32'hFFFFFFFF, 32'hFFFFFFF9, 32'd2, 1'b1, 1'b1, 1'b0}, 1'b1,
          '{32'hFFFFFFFC, 32'h0, 32'd1, STATUS_OK}},
        '{'{32'h0, 32'd7, 32'hFFFFFFFE, 1'b1, 1'b0, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'h0, 32'd7, 32'hFFFFFFFE, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'hFFFFFFFF, 32'hFFFFFFF9, 32'hFFFFFFFE, 1'b1, 1'b1, 1'b0}, 1'b0,
          NO_RESULT},
        '{'{32'h0, 32'd7, 32'd2, 1'b0, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'h80000000, 32'h0, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b1}, 1'b1,
          '{32'h0, 32'h80000000, 32'h0, STATUS_OK}},
        '{'{32'h80000000, 32'h0, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{32'h0, 32'h0, 32'h0, STATUS_RANGE}},
        '{'{32'hFFFFFFFF, 32'h80000000, 32'h1, 1'b1, 1'b0, 1'b0}, 1'b0,
          NO_RESULT},
        '{'{32'h0, 32'h80000000, 32'h1, 1'b1, 1'b0, 1'b0}, 1'b1,
          '{32'h0, 32'h0, 32'h0, STATUS_RANGE}},
        '{'{32'h0, 32'h1, 32'h80000000, 1'b1, 1'b1, 1'b0}, 1'b0, NO_RESULT},
        '{'{32'hFFFFFFFF, 32'hFFFFFFF8, 32'd2, 1'b1, 1'b1, 1'b0}, 1'b0,
          NO_RESULT},
        '{'{32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 1'b1, 1'b1, 1'b0}, 1'b0,
          NO_RESULT},
        '{'{32'h12345678, 32'h9ABCDEF0, 32'h0000FFFF, 1'b1, 1'b0, 1'b1}, 1'b0,
          NO_RESULT},
        '{'{32'h80000000, 32'h0, 32'h1, 1'b0, 1'b1, 1'b1}, 1'b0, NO_RESULT}
    };

    word_t corner_words [5] = '{32'h0, 32'h1, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF};

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [S_TDATA_BITS-1:0] s_axis_tdata  = '0;
    logic [S_TUSER_BITS-1:0] s_axis_tuser  = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_axis_tdata;
    logic [M_TUSER_BITS-1:0] m_axis_tuser;

    div_result_t pending_quotients [$];
    int          error_count   = 0;
    int          idle_cycles   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    double_word_divider_unit i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Exact division on magnitudes, then sign, floor and range handling
    function automatic div_result_t divide_words(input div_request_t req);
        div_result_t res;
        dword_t      num;
        dword_t      quo;
        word_t       den;
        word_t       rem;
        logic        num_neg;
        logic        den_neg;
        res = '0;
        res.status = STATUS_OK;
        if (req.divisor == '0)
        begin
            res.status = STATUS_DIV_ZERO;
            return res;
        end
        num     = {req.dividend_high, req.dividend_low};
        num_neg = req.signed_mode && num[DWORD_BITS-1];
        den_neg = req.signed_mode && req.divisor[WORD_BITS-1];
        if (num_neg)
            num = -num;
        den = den_neg ? -req.divisor : req.divisor;
        quo = num / {{WORD_BITS{1'b0}}, den};
        rem = word_t'(num % {{WORD_BITS{1'b0}}, den});
        if (num_neg != den_neg)
            quo = -quo;
        if (num_neg)
            rem = -rem;
        // floored: step the quotient down and move the remainder to the divisor's sign
        if (req.signed_mode && req.floor_mode && rem != '0 && num_neg != den_neg)
        begin
            quo = quo - dword_t'(1);
            rem = rem + req.divisor;
        end
        if (!req.wide_quotient)
        begin
            if (req.signed_mode ? !(quo[DWORD_BITS-1:WORD_BITS-1] == '0 ||
                                    quo[DWORD_BITS-1:WORD_BITS-1] == '1)
                                : quo[DWORD_BITS-1:WORD_BITS] != '0)
            begin
                res.status = STATUS_RANGE;
                return res;
            end
            quo[DWORD_BITS-1:WORD_BITS] = '0;
        end
        res.quotient_low  = quo[WORD_BITS-1:0];
        res.quotient_high = quo[DWORD_BITS-1:WORD_BITS];
        res.remainder     = rem;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Hold the request until accepted; tvalid is lowered only in idle cycles
    task automatic send_request(input div_request_t req, input logic has_result,
                                input div_result_t typed_result);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.divisor, req.dividend_low, req.dividend_high};
        s_axis_tuser  <= {req.wide_quotient, req.floor_mode, req.signed_mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_quotients.push_back(has_result ? typed_result : divide_words(req));
    endtask

    always @(posedge clk)
    begin : result_check
        div_result_t got;
        div_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.quotient_low  = m_axis_tdata[WORD_BITS-1:0];
            got.quotient_high = m_axis_tdata[2*WORD_BITS-1:WORD_BITS];
            got.remainder     = m_axis_tdata[3*WORD_BITS-1:2*WORD_BITS];
            got.status        = status_t'(m_axis_tuser);
            if (pending_quotients.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = pending_quotients.pop_front();
                if (got.quotient_low !== want.quotient_low)
                    report_mismatch($sformatf("quotient_low %h, want %h",
                                              got.quotient_low, want.quotient_low));
                if (got.quotient_high !== want.quotient_high)
                    report_mismatch($sformatf("quotient_high %h, want %h",
                                              got.quotient_high, want.quotient_high));
                if (got.remainder !== want.remainder)
                    report_mismatch($sformatf("remainder %h, want %h",
                                              got.remainder, want.remainder));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got.status, want.status));
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        div_request_t req;
        dword_t       num;
        word_t        den_half;
        word_t        den_mag;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
            send_request(directed_table[i].req, directed_table[i].has_result,
                         directed_table[i].res);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = PHASE_SEND_IDLE[phase];
            stall_pct     = PHASE_STALL[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                req.signed_mode   = $urandom_range(0, 1);
                req.floor_mode    = $urandom_range(0, 1);
                req.wide_quotient = $urandom_range(0, 1);
                case ($urandom_range(0, 9)) inside
                    0:       req.divisor = '0;
                    1:       req.divisor = corner_words[$urandom_range(1, 4)];
                    [2:3]:   req.divisor = $urandom_range(1, 15);
                    default: req.divisor = $urandom;
                endcase
                den_mag = (req.signed_mode && req.divisor[WORD_BITS-1]) ?
                          -req.divisor : req.divisor;
                den_half = den_mag >> 1;
                case ($urandom_range(0, 7))
                    0:
                    begin
                        num = {$urandom, $urandom};
                    end
                    1:
                    begin
                        num = {corner_words[$urandom_range(0, 4)],
                               corner_words[$urandom_range(0, 4)]};
                    end
                    2:
                    begin
                        num[WORD_BITS-1:0] = $urandom;
                        num[DWORD_BITS-1:WORD_BITS] = req.signed_mode ?
                            {WORD_BITS{num[WORD_BITS-1]}} : '0;
                    end
                    default:
                    begin
                        // keep the quotient within one word most of the time
                        num[WORD_BITS-1:0] = $urandom;
                        num[DWORD_BITS-1:WORD_BITS] =
                            (den_half != '0) ? word_t'($urandom % den_half) : '0;
                        if (req.signed_mode && $urandom_range(0, 1))
                            num = -num;
                    end
                endcase
                req.dividend_high = num[DWORD_BITS-1:WORD_BITS];
                req.dividend_low  = num[WORD_BITS-1:0];
                send_request(req, 1'b0, NO_RESULT);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending_quotients.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
design/dwdiv_pkg.sv
design/dwdiv_datapath.sv
design/dwdiv_ctrl.sv
design/double_word_divider_unit.sv
dv/double_word_divider_unit_test.sv
